/* hw/rtl/ghmt_pkg.sv */
package ghmt_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_MERGE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_REMOVED = 2'd1;
	localparam logic [1:0] KIND_GOSSIP  = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	localparam logic [1:0] REG_SELF_ID   = 2'd0;
	localparam logic [1:0] REG_SELF_PORT = 2'd1;
	localparam logic [1:0] REG_TIMEOUT   = 2'd2;
	localparam logic [1:0] REG_PERIOD    = 2'd3;

	localparam int CFG_DATA_W = 32;

	localparam int ENTRY_W = 32 + 16 + 32 + 32;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] current_time;
		logic [31:0] entry_id;
		logic [15:0] entry_port;
		logic [31:0] entry_heartbeat;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] member_id;
		logic [15:0] member_port;
		logic [31:0] member_heartbeat;
		logic        inserted;
		logic        table_full;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] port;
		logic [31:0] beat;
		logic [31:0] stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch input word
		logic clear_scan; // reset scan index
		logic step;       // advance scan index
		logic rd;         // issue RAM read at scan index
		logic find_cap;   // compare read data for match/free slot
		logic self_wr;    // write refreshed self entry
		logic merge_wr;   // write merge update/insert
		logic age_cap;    // test age and remove
		logic gossip_cap; // output gossip record
		logic tick_done;  // output tick done
		logic done_out;   // output merge/clear done
		logic do_clear;   // clear all valid bits
		logic cd_update;  // advance countdown
		logic mark_last;  // release the held word as the final one
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;   // scan index at final entry
		logic out_busy;   // output register holds an unsent word
		logic op_tick;
		logic op_merge;
		logic op_clear;
		logic gossip_due; // countdown expires this tick
		logic any_out;    // a result was produced in this tick
	} sts_t;

endpackage

/* hw/rtl/gossip_heartbeat_membership_table_core.sv */
// channel | direction | handshake             | word
// in      | input     | in_valid / in_ready   | in_word_t: operation, time, entry fields
// out     | output    | out_valid / out_ready | out_word_t: kind, member fields, flags
// cfg     | input     | cfg_we (no stall)     | cfg_idx, cfg_data
// A merge performs a lookup scan of the table, reading and checking one entry at a time.
// A tick performs a lookup scan and an age scan, and a gossip scan as well when gossip
// is due; a clear or an undefined operation performs no scan.
// Reset clears the valid bits and the control state; entry contents are left as they are.
// The age and gossip scans hold while the output register is full, and in_ready stays low while it is.
module gossip_heartbeat_membership_table_core import ghmt_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_word_t        in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output out_word_t       out_word,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_t ctl;
	sts_t sts;

	ghmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_valid && in_ready),
		.sts      (sts),
		.ctl      (ctl),
		.in_ready (in_ready)
	);

	ghmt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

endmodule

/* hw/rtl/ghmt_ram.sv */
module ghmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/ghmt_datapath.sv */
module ghmt_datapath import ghmt_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  in_word_t        in_word,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctl_t            ctl,
	output sts_t            sts,
	input  logic            out_ready,
	output logic            out_valid,
	output out_word_t       out_word
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	logic [31:0] self_id_q;
	logic [15:0] self_port_q;
	logic [15:0] timeout_q;
	logic [7:0]  period_q;
	logic [7:0]  countdown_q;

	in_word_t    in_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] rd_idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic          hit_q, free_q, any_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	entry_t        hit_ent_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata, ram_rdata;

	out_word_t out_q;
	out_word_t held_q;
	logic      out_valid_q;

	ghmt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	logic [31:0] key_id;
	logic [15:0] key_port;
	logic        is_match;
	logic [31:0] age;
	logic [7:0]  cd_next;
	logic        remove_hit;
	logic        cap_hit;
	out_word_t   cap_word;
	logic        out_load;
	out_word_t   out_d;

	always_comb begin
		key_id   = (in_q.operation == OP_TICK) ? self_id_q : in_q.entry_id;
		key_port = (in_q.operation == OP_TICK) ? self_port_q : in_q.entry_port;
		is_match = valid_q[rd_idx_q] && ram_rdata.id == key_id && ram_rdata.port == key_port;
		age      = in_q.current_time - ram_rdata.stamp;
		cd_next  = countdown_q - 8'd1;
	end

	// a produced record waits in held_q until the next one shows it was not the final one
	always_comb begin
		remove_hit = ctl.age_cap && valid_q[rd_idx_q] && age > {16'd0, timeout_q};
		cap_hit    = remove_hit || (ctl.gossip_cap && valid_q[rd_idx_q]);
		cap_word   = '{result_kind: ctl.age_cap ? KIND_REMOVED : KIND_GOSSIP,
			member_id: ram_rdata.id, member_port: ram_rdata.port,
			member_heartbeat: ram_rdata.beat,
			inserted: 1'b0, table_full: 1'b0, last: 1'b0};
		out_load   = 1'b0;
		out_d      = held_q;
		if (cap_hit) begin
			out_load = any_q;
		end else if (ctl.mark_last) begin
			out_load   = 1'b1;
			out_d.last = 1'b1;
		end else if (ctl.tick_done) begin
			out_load = 1'b1;
			out_d    = '{result_kind: KIND_TICK, last: 1'b1, default: '0};
		end else if (ctl.done_out) begin
			out_load = 1'b1;
			out_d    = '{result_kind: KIND_DONE,
				inserted: in_q.operation == OP_MERGE && !hit_q && free_q,
				table_full: in_q.operation == OP_MERGE && !hit_q && !free_q,
				last: 1'b1, default: '0};
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = hit_ent_q;
		if (ctl.self_wr && hit_q) begin
			ram_we          = 1'b1;
			ram_wdata.stamp = in_q.current_time;
			if (hit_ent_q.beat != 32'hFFFF_FFFF) begin
				ram_wdata.beat = hit_ent_q.beat + 32'd1;
			end
		end else if (ctl.merge_wr) begin
			if (hit_q) begin
				ram_we          = hit_ent_q.beat < in_q.entry_heartbeat;
				ram_wdata.beat  = in_q.entry_heartbeat;
				ram_wdata.stamp = in_q.current_time;
			end else begin
				ram_we    = free_q;
				ram_waddr = free_idx_q;
				ram_wdata = '{id: in_q.entry_id, port: in_q.entry_port,
					beat: in_q.entry_heartbeat, stamp: in_q.current_time};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q   <= '0;
			self_port_q <= '0;
			timeout_q   <= 16'd20;
			period_q    <= 8'd5;
			countdown_q <= 8'd5;
			in_q        <= '0;
			valid_q     <= '0;
			idx_q       <= '0;
			rd_idx_q    <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			any_q       <= 1'b0;
			hit_idx_q   <= '0;
			free_idx_q  <= '0;
			hit_ent_q   <= '0;
			held_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SELF_ID:   self_id_q   <= cfg_data;
					REG_SELF_PORT: self_port_q <= cfg_data[15:0];
					REG_TIMEOUT:   timeout_q   <= cfg_data[15:0];
					REG_PERIOD:    period_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= out_d;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.load) begin
				in_q  <= in_word;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				any_q <= 1'b0;
			end
			if (ctl.clear_scan) begin
				idx_q <= '0;
			end else if (ctl.step) begin
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.rd) begin
				rd_idx_q <= idx_q;
			end
			if (ctl.find_cap) begin
				if (is_match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_q;
					hit_ent_q <= ram_rdata;
				end
				if (!valid_q[rd_idx_q] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_q;
				end
			end
			if (ctl.merge_wr && !hit_q && free_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (ctl.do_clear) begin
				valid_q <= '0;
			end
			if (ctl.cd_update) begin
				countdown_q <= (cd_next == 8'd0) ? period_q : cd_next;
			end
			if (remove_hit) begin
				valid_q[rd_idx_q] <= 1'b0;
			end
			if (cap_hit) begin
				any_q  <= 1'b1;
				held_q <= cap_word;
			end
		end
	end

	always_comb begin
		sts.scan_end   = rd_idx_q == LAST_IDX;
		sts.out_busy   = out_valid_q && !out_ready;
		sts.op_tick    = in_q.operation == OP_TICK;
		sts.op_merge   = in_q.operation == OP_MERGE;
		sts.op_clear   = in_q.operation == OP_CLEAR;
		sts.gossip_due = cd_next == 8'd0;
		sts.any_out    = any_q;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

/* hw/rtl/ghmt_ctrl.sv */
module ghmt_ctrl import ghmt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  sts_t sts,
	output ctl_t ctl,
	output logic in_ready
);

	// Each scan: RD issues the read of entry idx, next cycle the data is checked.
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_FRD    = 9'b000000010,
		S_FCHK   = 9'b000000100,
		S_UPD    = 9'b000001000,
		S_ARD    = 9'b000010000,
		S_ACHK   = 9'b000100000,
		S_GRD    = 9'b001000000,
		S_GCHK   = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   gossip_q;

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !sts.out_busy;
				if (in_fire) begin
					ctl.load       = 1'b1;
					ctl.clear_scan = 1'b1;
					state_d        = S_FRD;
				end
			end
			S_FRD: begin
				if (sts.op_tick || sts.op_merge) begin
					ctl.rd   = 1'b1;
					ctl.step = 1'b1;
					state_d  = S_FCHK;
				end else begin
					ctl.do_clear = sts.op_clear;
					state_d      = S_FIN;
				end
			end
			S_FCHK: begin
				ctl.find_cap = 1'b1;
				state_d = sts.scan_end ? S_UPD : S_FRD;
			end
			S_UPD: begin
				ctl.clear_scan = 1'b1;
				if (sts.op_tick) begin
					ctl.self_wr   = 1'b1;
					ctl.cd_update = 1'b1;
					state_d       = S_ARD;
				end else begin
					ctl.merge_wr = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_ARD: begin
				if (!sts.out_busy) begin
					ctl.rd   = 1'b1;
					ctl.step = 1'b1;
					state_d  = S_ACHK;
				end
			end
			S_ACHK: begin
				ctl.age_cap = 1'b1;
				if (sts.scan_end) begin
					ctl.clear_scan = 1'b1;
					state_d = gossip_q ? S_GRD : S_FIN;
				end else begin
					state_d = S_ARD;
				end
			end
			S_GRD: begin
				if (!sts.out_busy) begin
					ctl.rd   = 1'b1;
					ctl.step = 1'b1;
					state_d  = S_GCHK;
				end
			end
			S_GCHK: begin
				ctl.gossip_cap = 1'b1;
				state_d = sts.scan_end ? S_FIN : S_GRD;
			end
			S_FIN: begin
				// a tick with records releases the held one as final, else emit the done word
				if (!sts.out_busy) begin
					ctl.mark_last = sts.op_tick && sts.any_out;
					ctl.tick_done = sts.op_tick && !sts.any_out;
					ctl.done_out  = !sts.op_tick;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			gossip_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.cd_update) begin
				gossip_q <= sts.gossip_due;
			end
		end
	end

endmodule

/* hw/rtl/ghmt_checker.sv */
module ghmt_checker import ghmt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_no_accept_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_flags_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.inserted || out_word.table_full) |->
		out_word.result_kind == KIND_DONE && out_word.last)
		else $error("merge flags on a non-final word");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.inserted && out_word.table_full))
		else $error("inserted and full both set");

endmodule

bind gossip_heartbeat_membership_table_core ghmt_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
